// ===== hw/rtl/asa_pkg.sv =====
package asa_pkg;

	localparam int AVG_DEPTH_DEF   = 32;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int SLEW_STEP       = 5;
	localparam int POS_BITS        = 8;
	localparam int FULL_POS        = 255;
	localparam int ZERO_RANGE_DIV  = 100;
	localparam int CFG_ADDR_BITS   = 2;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_CAL_LOW  = 2'd0,
		REG_CAL_HIGH = 2'd1,
		REG_FLIP     = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_MEAN_LD,
		ST_PREP,
		ST_SCALE_LD,
		ST_SCALE_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic mem_rd;
		logic upd;
		logic mean_ld;
		logic prep;
		logic scale_ld;
		logic div_step;
		logic out_ld;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_full;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/asa_ctrl.sv =====
module asa_ctrl
	import asa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam int CW = $clog2(POS_BITS);

	state_t        state_q, state_nxt;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SCALE_LD)
				cnt_q <= CW'(POS_BITS - 1);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_nxt = ST_READ;
			ST_READ:      state_nxt = ST_UPDATE;
			ST_UPDATE:    state_nxt = ST_MEAN_LD;
			ST_MEAN_LD:   state_nxt = ST_PREP;
			ST_PREP:      state_nxt = ST_SCALE_LD;
			ST_SCALE_LD:  state_nxt = ST_SCALE_DIV;
			ST_SCALE_DIV: if (cnt_q == '0) state_nxt = ST_DONE;
			ST_DONE:      if (!sts.out_full) state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_READ:      cmd.mem_rd   = 1'b1;
			ST_UPDATE:    cmd.upd      = 1'b1;
			ST_MEAN_LD:   cmd.mean_ld  = 1'b1;
			ST_PREP:      cmd.prep     = 1'b1;
			ST_SCALE_LD:  cmd.scale_ld = 1'b1;
			ST_SCALE_DIV: cmd.div_step = 1'b1;
			ST_DONE:      cmd.out_ld   = !sts.out_full;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/asa_datapath.sv =====
module asa_datapath
	import asa_pkg::*;
#(
	parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_cmd_t                 cmd,
	output ctl_sts_t                 sts,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [SAMPLE_BITS-1:0]   cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [POS_BITS-1:0]      position,
	output logic [SAMPLE_BITS-1:0]   smoothed
);

	localparam int SB  = SAMPLE_BITS;
	localparam int SW  = $clog2(AVG_DEPTH);
	localparam int TW  = SB + SW;
	localparam int DVW = SB + 1;
	localparam int PW  = SB + POS_BITS;
	localparam int RK  = TW + SW;
	localparam int RMW = TW + 2;
	localparam logic [63:0] RECIP = ((64'd1 << RK) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);

	logic [SB-1:0]        cal_low_q, cal_high_q;
	logic                 flip_q;

	logic [SB-1:0]        held_q;
	logic [SW-1:0]        slot_q;
	logic [SB-1:0]        mem_q [AVG_DEPTH];
	logic [AVG_DEPTH-1:0] vld_q;
	logic [SB-1:0]        rd_q;
	logic                 rd_vld_q;
	logic [TW-1:0]        total_q;

	logic [DVW-1:0]       rem_q, div_q;
	logic [SB-1:0]        dq_q;

	logic [SB-1:0]        mean_q, diff_q, rng_q;
	logic                 bad_q;

	logic                 out_valid_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [SB-1:0]        smooth_q;

	logic [SB:0]          h_ext, s_ext;
	logic [SB-1:0]        slew_val;
	logic [DVW:0]         trial;
	logic                 ge;
	logic [SB-1:0]        clamped;
	logic [PW-1:0]        prod;
	logic [POS_BITS-1:0]  quo8;
	logic [TW+RMW-1:0]    mean_prod;

	// slew limiter
	always_comb begin
		h_ext = {1'b0, held_q};
		s_ext = {1'b0, sample};
		if (s_ext > h_ext + (SB+1)'(SLEW_STEP))
			slew_val = held_q + SB'(SLEW_STEP);
		else if (s_ext + (SB+1)'(SLEW_STEP) < h_ext)
			slew_val = held_q - SB'(SLEW_STEP);
		else
			slew_val = sample;
	end

	// restoring divider step
	always_comb begin
		trial = {rem_q, dq_q[SB-1]};
		ge    = trial >= {1'b0, div_q};
	end

	always_comb begin
		if (mean_q < cal_low_q)
			clamped = cal_low_q;
		else if (mean_q > cal_high_q)
			clamped = cal_high_q;
		else
			clamped = mean_q;
	end

	// total / AVG_DEPTH, exact over the full total range
	assign mean_prod = (TW+RMW)'(total_q) * (TW+RMW)'(RECIP[RMW-1:0]);

	assign prod = {diff_q, {POS_BITS{1'b0}}} - PW'(diff_q);
	assign quo8 = dq_q[POS_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_low_q   <= '0;
			cal_high_q  <= '1;
			flip_q      <= 1'b0;
			held_q      <= SB'(1) << (SB - 1);
			slot_q      <= '0;
			vld_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_CAL_LOW:  cal_low_q  <= cfg_data;
					REG_CAL_HIGH: cal_high_q <= cfg_data;
					REG_FLIP:     flip_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				held_q <= slew_val;
				slot_q <= (slot_q == SW'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.upd) begin
				vld_q[slot_q] <= 1'b1;
				total_q <= total_q - (rd_vld_q ? TW'(rd_q) : '0) + TW'(held_q);
			end
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// history ring
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_q     <= mem_q[slot_q];
			rd_vld_q <= vld_q[slot_q];
		end
		if (cmd.upd)
			mem_q[slot_q] <= held_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.scale_ld) begin
			rem_q <= DVW'(prod >> POS_BITS);
			dq_q  <= SB'(prod[POS_BITS-1:0]) << (SB - POS_BITS);
			div_q <= DVW'(rng_q);
		end else if (cmd.div_step) begin
			rem_q <= ge ? DVW'(trial - {1'b0, div_q}) : trial[DVW-1:0];
			dq_q  <= {dq_q[SB-2:0], ge};
		end
		if (cmd.mean_ld)
			mean_q <= SB'(mean_prod >> RK);
		if (cmd.prep) begin
			diff_q <= clamped - cal_low_q;
			rng_q  <= (cal_high_q == cal_low_q) ? SB'(ZERO_RANGE_DIV)
			                                    : cal_high_q - cal_low_q;
			bad_q  <= cal_high_q < cal_low_q;
		end
		if (cmd.out_ld) begin
			smooth_q <= mean_q;
			if (bad_q)
				pos_q <= '0;
			else if (flip_q)
				pos_q <= POS_BITS'(FULL_POS) - quo8;
			else
				pos_q <= quo8;
		end
	end

	assign sts.out_full = out_valid_q & ~out_ready;
	assign out_valid    = out_valid_q;
	assign position     = pos_q;
	assign smoothed     = smooth_q;

endmodule

// ===== hw/rtl/adc_slew_average_scale.sv =====
// Slew-limited, moving-averaged ADC axis scaled to 0..255. Each sample moves a held value
// by at most 5 counts, the held value enters an AVG_DEPTH-entry ring whose running sum gives
// the mean (smoothed), and the mean is clamped to [cal_low, cal_high] and scaled to a position
// (inverted when flip is set, 0 when cal_high < cal_low, zero range divides by 100).
// A sample is accepted only while the block is idle, and its result is computed in steps before
// the next one is taken: ring read and running-sum update, a reciprocal multiply for the mean,
// calibration setup, then a restoring divider for the position. The next sample is
// taken while the last result is still held on the output; a result stalled beyond that
// holds back the following one.
module adc_slew_average_scale
	import asa_pkg::*;
#(
	parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + POS_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_W-1:0]          s_tdata,  // sample
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_W-1:0]         m_tdata,  // position, smoothed
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [SAMPLE_BITS-1:0]   cfg_data
);

	ctl_cmd_t                 cmd;
	ctl_sts_t                 sts;
	logic [POS_BITS-1:0]      position;
	logic [SAMPLE_BITS-1:0]   smoothed;

	asa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	asa_datapath #(
		.AVG_DEPTH  (AVG_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (s_tdata[SAMPLE_BITS-1:0]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.position  (position),
		.smoothed  (smoothed)
	);

	assign m_tdata = OUT_W'({smoothed, position});

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import asa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;

	typedef struct packed {
		logic [7:0]  position;
		logic [11:0] smoothed;
	} axis_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // sample
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // position, smoothed
	logic        cfg_we   = 1'b0;
	reg_idx_t    cfg_addr = REG_CAL_LOW;
	logic [11:0] cfg_data = '0;

	// axis model state
	logic [11:0] p_held = 12'd2048;
	logic [11:0] p_ring [AVG_DEPTH_DEF] = '{default: '0};
	logic [4:0]  p_slot = '0;
	logic [16:0] p_total = '0;
	logic [11:0] c_low = 12'd0;
	logic [11:0] c_high = 12'd4095;
	logic        c_flip = 1'b0;

	axis_result_t pos_expect_q [$];
	axis_result_t want;

	int errors = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int cal_settings = 0;
	int idle_cycles = 0;

	logic quiet_mode = 1'b0;
	logic hold_trigger = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	always #1 clk = ~clk;

	adc_slew_average_scale uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	function automatic logic [7:0] scale_position(input logic [11:0] mean);
		int unsigned cv;
		int unsigned span;
		int unsigned q;
		logic [7:0] pos;
		if (c_high < c_low)
			return 8'd0;
		cv = mean;
		if (cv < c_low)
			cv = c_low;
		else if (cv > c_high)
			cv = c_high;
		span = c_high - c_low;
		if (span == 0)
			span = ZERO_RANGE_DIV;
		q = ((cv - c_low) * FULL_POS) / span;
		pos = q[7:0];
		if (c_flip)
			pos = 8'(FULL_POS) - pos;
		return pos;
	endfunction

	task automatic axis_predict(input logic [11:0] smp);
		int h;
		int v;
		axis_result_t r;
		h = p_held;
		v = smp;
		if (v > h + SLEW_STEP)
			h = h + SLEW_STEP;
		else if (v < h - SLEW_STEP)
			h = h - SLEW_STEP;
		else
			h = v;
		p_held = h[11:0];
		p_slot = p_slot + 5'd1;
		p_total = p_total - 17'(p_ring[p_slot]) + 17'(p_held);
		p_ring[p_slot] = p_held;
		r.smoothed = p_total[16:5];
		r.position = scale_position(r.smoothed);
		pos_expect_q.push_back(r);
	endtask

	task automatic send_sample(input logic [11:0] smp);
		while (!quiet_mode && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		axis_predict(smp);
		samples_sent++;
	endtask

	task automatic finish_burst();
		s_tvalid <= 1'b0;
		while (pos_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_calibration(input logic [11:0] lo, input logic [11:0] hi,
			input logic flp);
		finish_burst();
		cfg_we <= 1'b1;
		cfg_addr <= REG_CAL_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_addr <= REG_CAL_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_addr <= REG_FLIP;
		cfg_data <= {11'd0, flp};
		@(posedge clk);
		cfg_we <= 1'b0;
		c_low = lo;
		c_high = hi;
		c_flip = flp;
		cal_settings++;
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [11:0] seq [12] = '{12'd2048, 12'd2053, 12'd2054, 12'd2040, 12'd4095,
			12'd0, 12'h555, 12'hAAA, 12'hFFF, 12'h000, 12'd2049, 12'd7};
		foreach (seq[i])
			send_sample(seq[i]);
		set_calibration(12'd0, 12'd4095, 1'b1);
		send_sample(12'd4095);
		send_sample(12'd0);
		// zero range, both polarities
		set_calibration(12'd1000, 12'd1000, 1'b0);
		send_sample(12'd2000);
		set_calibration(12'd1000, 12'd1000, 1'b1);
		send_sample(12'd2000);
		// inverted calibration
		set_calibration(12'd3000, 12'd200, 1'b1);
		send_sample(12'd1500);
		set_calibration(12'd4095, 12'd4095, 1'b1);
		send_sample(12'd4095);
		set_calibration(12'd0, 12'd0, 1'b0);
		send_sample(12'd0);
		set_calibration(12'd0, 12'd4095, 1'b0);
	endtask

	task automatic test_slew_floor();
		int n;
		n = 0;
		while (p_held >= SLEW_STEP && n < 600) begin
			send_sample(12'($urandom_range(0, 2)));
			n++;
		end
		repeat (40)
			send_sample(12'($urandom_range(0, 12)));
		finish_burst();
	endtask

	task automatic test_random_walk();
		int m;
		int lo;
		int hi;
		int target;
		int smp;
		int mode;
		for (int ph = 0; ph < 6; ph++) begin
			m = p_total[16:5];
			case ($urandom_range(0, 9))
				0: begin
					lo = $urandom_range(0, 4095);
					hi = lo;
				end
				1: begin
					hi = $urandom_range(0, 4000);
					lo = hi + $urandom_range(1, 95);
				end
				2: begin
					lo = 0;
					hi = 4095;
				end
				default: begin
					lo = m - int'($urandom_range(0, 300));
					hi = m + int'($urandom_range(0, 300));
					if (lo < 0)
						lo = 0;
					if (hi > 4095)
						hi = 4095;
				end
			endcase
			set_calibration(12'(lo), 12'(hi), 1'($urandom_range(0, 1)));
			target = $urandom_range(0, 4095);
			repeat (100) begin
				mode = $urandom_range(0, 99);
				if (mode < 45)
					smp = target + int'($urandom_range(0, 16)) - 8;
				else if (mode < 75)
					smp = int'(p_held) + int'($urandom_range(0, 12)) - 6;
				else
					smp = $urandom_range(0, 4095);
				if (smp < 0)
					smp = 0;
				if (smp > 4095)
					smp = 4095;
				send_sample(12'(smp));
			end
		end
		finish_burst();
	endtask

	task automatic test_backpressure();
		quiet_mode <= 1'b1;
		hold_trigger <= 1'b1;
		repeat (80)
			send_sample(12'($urandom_range(0, 4095)));
		finish_burst();
		quiet_mode <= 1'b0;
	endtask

	// receiver
	always @(posedge clk) begin
		if (hold_trigger && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_mode || ($urandom_range(99) >= 23);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pos_expect_q.size() == 0) begin
				$display("%0t: unexpected transaction position=%0d smoothed=%0d",
					$time, m_tdata[7:0], m_tdata[19:8]);
				errors++;
			end else begin
				want = pos_expect_q.pop_front();
				results_checked++;
				if (m_tdata[7:0] !== want.position) begin
					$display("%0t: position mismatch expected=%0d actual=%0d",
						$time, want.position, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[19:8] !== want.smoothed) begin
					$display("%0t: smoothed mismatch expected=%0d actual=%0d",
						$time, want.smoothed, m_tdata[19:8]);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, %0d results outstanding", $time,
					pos_expect_q.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_slew_floor();
		test_random_walk();
		test_backpressure();
		repeat (40) @(posedge clk);
		$display("Sent %0d samples, checked %0d results over %0d calibration settings",
			samples_sent, results_checked, cal_settings);
		$display("Covered slew floor, zero and inverted ranges, flip and output stall");
		if (errors == 0 && pos_expect_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
